// File: rtl/stdk_pkg.sv
// shared types and constants for the sub-audible tone keyer
package stdk_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PTT_INVERT = 1'd1;

    localparam logic [7:0] LEVEL_RESET = 8'd255;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_START = 2'd1,
        MODE_ON    = 2'd2,
        MODE_TAIL  = 2'd3
    } mode_t;

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_CONTROL = 1'b1
    } op_t;

    // sin(pi*i/16) in q15
    localparam logic [15:0] HALF_WAVE_Q15 [16] = '{
        16'd0,     16'd6393,  16'd12540, 16'd18205,
        16'd23170, 16'd27245, 16'd30274, 16'd32138,
        16'd32768, 16'd32138, 16'd30274, 16'd27245,
        16'd23170, 16'd18205, 16'd12540, 16'd6393
    };

    typedef struct packed {
        logic       op;
        logic       ptt_active;
        logic       tone_disable;
        logic       reverse_request;
        logic [7:0] level_sample;
    } stdk_in_t;

    typedef struct packed {
        logic [9:0] duty;
        logic       pwm_on;
        logic       ptt_out;
        logic [1:0] tone_state;
    } stdk_out_t;

endpackage

// File: rtl/stdk_duty.sv
// sine sample lookup and amplitude scaling into a ten-bit pwm duty
module stdk_duty #(
    parameter int SINE_MID = 127
) (
    input  logic [4:0] index,
    input  logic [7:0] level,
    output logic [9:0] duty
);
    import stdk_pkg::*;

    localparam int SCALE = 512 / (SINE_MID + 1);

    function automatic logic [31:0][7:0] build_lut(input int mid);
        logic [31:0][7:0] lut;
        int               h;
        for (int a = 0; a < 32; a++)
        begin
            h = (mid * int'(HALF_WAVE_Q15[a % 16]) + 16384) / 32768;
            if (a >= 16)
            begin
                lut[a] = 8'(mid - h);
            end
            else
            begin
                lut[a] = 8'(mid + h);
            end
        end
        return lut;
    endfunction

    localparam logic [31:0][7:0] SINE_LUT = build_lut(SINE_MID);

    logic [7:0]  sample;
    logic [15:0] product;

    assign sample  = SINE_LUT[index];
    assign product = {8'd0, sample} * {8'd0, level};
    assign duty    = 10'(SCALE) * {2'd0, product[15:8]};

endmodule

// File: rtl/subaudible_tone_dds_keyer_unit.sv
// Keyed sub-audible tone generator: a 16-bit phase accumulator steps on each tick item
// while ticking, upward, or downward during a reverse burst; five accumulator bits pick
// a 32-point sine sample that is scaled by the held amplitude into a ten-bit pwm duty,
// and control items run the idle/start/on/tail keying sequence with a tail countdown of
// TAIL_TICKS ticks. One item is taken every clock cycle unless a stalled result holds
// back the next item. Each item is registered in the input register and its result in
// the result register, with the accumulator, sine lookup and 8x8 amplitude multiply
// combinational between them.
// Configuration writes take effect at the clock edge that carries them.
module subaudible_tone_dds_keyer_unit #(
    parameter int INDEX_SHIFT = 11,
    parameter int TAIL_TICKS  = 512,
    parameter int SINE_MID    = 127
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  stdk_pkg::stdk_in_t               item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output stdk_pkg::stdk_out_t              result,
    input  logic                             cfg_we,
    input  logic [stdk_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [stdk_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import stdk_pkg::*;

    localparam logic [15:0] TAIL_LOAD = 16'(TAIL_TICKS);

    logic        item_valid_reg;
    stdk_in_t    item_reg;
    logic        result_valid_reg;
    stdk_out_t   result_reg;

    logic [15:0] phase_step_reg;
    logic        ptt_invert_reg;
    mode_t       mode_reg,        mode_next;
    logic [15:0] phase_acc_reg,   phase_acc_next;
    logic        reverse_reg,     reverse_next;
    logic [15:0] tail_left_reg,   tail_left_next;
    logic [7:0]  level_reg,       level_next;
    logic        pwm_enabled_reg, pwm_enabled_next;
    logic        ticking_reg,     ticking_next;
    logic [9:0]  duty_reg,        duty_next;
    logic        ptt_keyed_reg,   ptt_keyed_next;

    logic        fire;
    logic        enable;
    logic [15:0] phase_sum;
    logic [9:0]  duty_calc;
    logic [7:0]  level_mid;
    logic [7:0]  diff;

    assign fire         = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall   = item_valid_reg && !fire;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign enable    = item_reg.ptt_active ^ ptt_invert_reg;
    assign phase_sum = reverse_reg ? (phase_acc_reg - phase_step_reg)
                                   : (phase_acc_reg + phase_step_reg);

    stdk_duty #(
        .SINE_MID(SINE_MID)
    ) u_duty (
        .index(phase_sum[INDEX_SHIFT+4:INDEX_SHIFT]),
        .level(level_reg),
        .duty (duty_calc)
    );

    always_comb
    begin
        mode_next        = mode_reg;
        phase_acc_next   = phase_acc_reg;
        reverse_next     = reverse_reg;
        tail_left_next   = tail_left_reg;
        level_next       = level_reg;
        pwm_enabled_next = pwm_enabled_reg;
        ticking_next     = ticking_reg;
        duty_next        = duty_reg;
        ptt_keyed_next   = ptt_keyed_reg;
        level_mid        = level_reg;
        diff             = 8'd0;
        if (fire)
        begin
            if (item_reg.op == OP_TICK)
            begin
                if (ticking_reg)
                begin
                    phase_acc_next = phase_sum;
                    duty_next      = duty_calc;
                    if (tail_left_reg != 16'd0)
                    begin
                        tail_left_next = tail_left_reg - 16'd1;
                    end
                end
            end
            else
            begin
                case (mode_reg)
                    MODE_IDLE:
                    begin
                        if (enable)
                        begin
                            mode_next = MODE_START;
                        end
                    end
                    MODE_START:
                    begin
                        reverse_next     = 1'b0;
                        level_mid        = item_reg.level_sample;
                        pwm_enabled_next = !item_reg.tone_disable;
                        ticking_next     = 1'b1;
                        ptt_keyed_next   = 1'b1;
                        mode_next        = MODE_ON;
                    end
                    MODE_ON:
                    begin
                        if (!enable)
                        begin
                            reverse_next = item_reg.reverse_request;
                            if (!item_reg.reverse_request)
                            begin
                                pwm_enabled_next = 1'b0;
                            end
                            tail_left_next = TAIL_LOAD;
                            mode_next      = MODE_TAIL;
                        end
                    end
                    default:
                    begin
                        if (tail_left_reg == 16'd0)
                        begin
                            ptt_keyed_next   = 1'b0;
                            pwm_enabled_next = 1'b0;
                            ticking_next     = 1'b0;
                            mode_next        = MODE_IDLE;
                        end
                        if (enable)
                        begin
                            mode_next = MODE_START;
                        end
                    end
                endcase
                // amplitude hysteresis
                diff = (item_reg.level_sample > level_mid) ? (item_reg.level_sample - level_mid)
                                                           : (level_mid - item_reg.level_sample);
                level_next = (diff[7:2] != 6'd0) ? item_reg.level_sample : level_mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
            ptt_invert_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PHASE_STEP: phase_step_reg <= cfg_data[15:0];
                CFG_PTT_INVERT: ptt_invert_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            phase_acc_reg   <= '0;
            reverse_reg     <= 1'b0;
            tail_left_reg   <= '0;
            level_reg       <= LEVEL_RESET;
            pwm_enabled_reg <= 1'b0;
            ticking_reg     <= 1'b0;
            duty_reg        <= '0;
            ptt_keyed_reg   <= 1'b0;
        end
        else
        begin
            mode_reg        <= mode_next;
            phase_acc_reg   <= phase_acc_next;
            reverse_reg     <= reverse_next;
            tail_left_reg   <= tail_left_next;
            level_reg       <= level_next;
            pwm_enabled_reg <= pwm_enabled_next;
            ticking_reg     <= ticking_next;
            duty_reg        <= duty_next;
            ptt_keyed_reg   <= ptt_keyed_next;
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
        begin
            item_reg <= item;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg.duty       <= duty_next;
            result_reg.pwm_on     <= pwm_enabled_next;
            result_reg.ptt_out    <= ptt_keyed_next;
            result_reg.tone_state <= mode_next;
        end
    end

endmodule

// File: rtl/stdk_check.sv
// port-level checks for the tone keyer and their binding to the top level
module stdk_check (
    input logic                clk,
    input logic                rst_n,
    input logic                result_valid,
    input logic                result_stall,
    input stdk_pkg::stdk_out_t result
);
    import stdk_pkg::*;

    // a stalled result holds until its transfer
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // pwm only runs while the transmitter is keyed
    a_pwm_keyed: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.pwm_on |-> result.ptt_out)
        else $error("pwm on without key");

    // idle means key and pwm both off
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.tone_state == MODE_IDLE) |-> !result.ptt_out && !result.pwm_on)
        else $error("idle with key or pwm active");

    // a newly entered tail state keeps the transmitter keyed
    a_tail_entry: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall ##1 result_valid && (result.tone_state == MODE_TAIL)
        && $changed(result.tone_state) |-> result.ptt_out)
        else $error("tail without key");

endmodule

bind subaudible_tone_dds_keyer_unit stdk_check u_stdk_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
);
